[hdl/ests_pkg.sv]
`timescale 1ns / 1ps
package ests_pkg;

  localparam int COEF_W    = 18;
  localparam int DIR_W     = 24;
  localparam int ROT_W     = 28;
  localparam int CW        = 32;
  localparam int ANG_W     = 32;
  localparam int SQ_W      = 56;
  localparam int ISQ_STEPS = 28;
  localparam int SIZE_W    = 13;
  localparam int IDX_W     = 18;
  localparam int RGB_W     = 24;
  localparam int ROW_W     = 54;

  typedef enum logic [2:0] {
    REG_ROT_X    = 3'd0,
    REG_ROT_Y    = 3'd1,
    REG_ROT_Z    = 3'd2,
    REG_SHIFT_U  = 3'd3,
    REG_SHIFT_V  = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6
  } cfg_reg_t;

  // item info that rides along with the math
  typedef struct packed {
    logic             sample;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
  } side_t;

  // arctangent of 2^-i as a binary angle, 2^32 is one turn
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

endpackage

[hdl/ests_delay.sv]
`timescale 1ns / 1ps
module ests_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

[hdl/ests_rotate.sv]
`timescale 1ns / 1ps
module ests_rotate import ests_pkg::*; (
  input  logic                    clk,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  input  logic [ROW_W-1:0]        row_x,
  input  logic [ROW_W-1:0]        row_y,
  input  logic [ROW_W-1:0]        row_z,
  output logic signed [ROT_W-1:0] rx,
  output logic signed [ROT_W-1:0] ry,
  output logic signed [ROT_W-1:0] rz
);

  logic [ROW_W-1:0]        rows [3];
  logic signed [DIR_W-1:0] dirs [3];
  logic signed [41:0]      prod [3][3];
  logic signed [43:0]      sum  [3];

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;
  assign dirs[0] = dir_x;
  assign dirs[1] = dir_y;
  assign dirs[2] = dir_z;

  // stage 1: nine products
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] <= $signed(rows[r][c*COEF_W +: COEF_W]) * dirs[c];
      end
    end
  end

  // stage 2: row sums, floor shift by 16
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      sum[r] <= 44'(prod[r][0]) + 44'(prod[r][1]) + 44'(prod[r][2]);
    end
  end

  assign rx = sum[0][43:16];
  assign ry = sum[1][43:16];
  assign rz = sum[2][43:16];

endmodule

[hdl/ests_isqrt.sv]
`timescale 1ns / 1ps
module ests_isqrt import ests_pkg::*; (
  input  logic                    clk,
  input  logic signed [ROT_W-1:0] rx,
  input  logic signed [ROT_W-1:0] rz,
  output logic [ROT_W-1:0]        root
);

  logic signed [SQ_W-1:0] ex, ez;
  logic [SQ_W-1:0] sqx, sqz;
  logic [SQ_W-1:0] rem [ISQ_STEPS+1];
  logic [SQ_W-1:0] res [ISQ_STEPS+1];

  assign ex = SQ_W'(rx);
  assign ez = SQ_W'(rz);

  always_ff @(posedge clk) begin
    sqx    <= ex * ex;
    sqz    <= ez * ez;
    rem[0] <= sqx + sqz;
    res[0] <= '0;
  end

  // one root bit per stage
  for (genvar s = 0; s < ISQ_STEPS; s++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - s));
    logic [SQ_W-1:0] trial;
    assign trial = res[s] + BIT;
    always_ff @(posedge clk) begin
      if (rem[s] >= trial) begin
        rem[s+1] <= rem[s] - trial;
        res[s+1] <= (res[s] >> 1) + BIT;
      end else begin
        rem[s+1] <= rem[s];
        res[s+1] <= res[s] >> 1;
      end
    end
  end

  assign root = res[ISQ_STEPS][ROT_W-1:0];

endmodule

[hdl/ests_cordic.sv]
`timescale 1ns / 1ps
module ests_cordic import ests_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic [ANG_W-1:0]     ang
);

  logic signed [CW-1:0] xs [STEPS+1];
  logic signed [CW-1:0] ys [STEPS+1];
  logic [ANG_W-1:0]     as [STEPS+1];
  logic                 zs [STEPS+1];

  // pre-rotation: left half plane turned by half a turn
  always_ff @(posedge clk) begin
    zs[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      xs[0] <= -x_in;
      ys[0] <= -y_in;
      as[0] <= 32'h8000_0000;
    end else begin
      xs[0] <= x_in;
      ys[0] <= y_in;
      as[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      zs[i+1] <= zs[i];
      if (ys[i] < 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        as[i+1] <= as[i] - ATAN_TAB[i];
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        as[i+1] <= as[i] + ATAN_TAB[i];
      end
    end
  end

  assign ang = zs[STEPS] ? '0 : as[STEPS];

endmodule

[hdl/ests_texmap.sv]
`timescale 1ns / 1ps
module ests_texmap import ests_pkg::*; #(
  parameter int MAX_TEXELS = 262144,
  parameter int MAX_DIM    = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  side_t             side,
  input  logic [ANG_W-1:0]  lon,
  input  logic [ANG_W-1:0]  lat,
  input  logic [15:0]       u_shift,
  input  logic [15:0]       v_shift,
  input  logic [SIZE_W-1:0] image_width,
  input  logic [SIZE_W-1:0] image_height,
  output logic              result_valid,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic [11:0]       texel_x,
  output logic [11:0]       texel_y
);

  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
  localparam logic [SIZE_W-1:0] MAX_SIZE =
    (MAX_DIM > 8191) ? 13'h1FFF : SIZE_W'(MAX_DIM);

  logic [ANG_W-1:0]  u, v;
  logic [SIZE_W-1:0] ws, hs;

  logic              s1_vld, s2_vld, s3_vld, s4_vld;
  side_t             s1_side, s2_side, s3_side, s4_side;
  logic [44:0]       s1_pu, s1_pv;
  logic [SIZE_W-1:0] s1_ws, s1_hs, s2_ws;
  logic [SIZE_W-1:0] px, py, tx, ty;
  logic [SIZE_W-1:0] s2_tx, s2_ty, s3_tx, s3_ty, s4_tx, s4_ty;
  logic [25:0]       s3_row;
  logic [26:0]       addr;
  logic [26:0]       s4_addr;
  logic              s4_hit, s4_wr_ok;

  logic [RGB_W-1:0]  mem [MAX_TEXELS];
  logic [RGB_W-1:0]  q;
  logic              q_hit;

  assign u  = 32'h8000_0000 - lon + {u_shift, 16'h0000};
  assign v  = 32'h8000_0000 - {lat[30:0], 1'b0} + {v_shift, 16'h0000};
  assign ws = (image_width > MAX_SIZE) ? MAX_SIZE : image_width;
  assign hs = (image_height > MAX_SIZE) ? MAX_SIZE : image_height;

  // stage 1: scale by image size
  always_ff @(posedge clk) begin
    s1_side <= side;
    s1_pu   <= 45'(u) * 45'(ws);
    s1_pv   <= 45'(v) * 45'(hs);
    s1_ws   <= ws;
    s1_hs   <= hs;
  end

  // stage 2: clamp to size-1
  assign px = s1_pu[44:32];
  assign py = s1_pv[44:32];
  assign tx = (s1_ws == '0) ? '0 : ((px > s1_ws - 1'b1) ? s1_ws - 1'b1 : px);
  assign ty = (s1_hs == '0) ? '0 : ((py > s1_hs - 1'b1) ? s1_hs - 1'b1 : py);

  always_ff @(posedge clk) begin
    s2_side <= s1_side;
    s2_tx   <= tx;
    s2_ty   <= ty;
    s2_ws   <= s1_ws;
  end

  // stage 3: row base
  always_ff @(posedge clk) begin
    s3_side <= s2_side;
    s3_row  <= 26'(s2_ty) * 26'(s2_ws);
    s3_tx   <= s2_tx;
    s3_ty   <= s2_ty;
  end

  // stage 4: linear address and range checks
  assign addr = 27'(s3_row) + 27'(s3_tx);

  always_ff @(posedge clk) begin
    s4_side  <= s3_side;
    s4_addr  <= addr;
    s4_hit   <= 32'(addr) < MAX_TEXELS;
    s4_wr_ok <= 32'(s3_side.idx) < MAX_TEXELS;
    s4_tx    <= s3_tx;
    s4_ty    <= s3_ty;
  end

  // stage 5: texel store, writes and reads kept in item order
  always_ff @(posedge clk) begin
    if (s4_vld && !s4_side.sample && s4_wr_ok) begin
      mem[AW'(s4_side.idx)] <= s4_side.rgb;
    end
    if (s4_vld && s4_side.sample) begin
      q <= mem[s4_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    q_hit   <= s4_hit;
    texel_x <= s4_tx[11:0];
    texel_y <= s4_ty[11:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      s3_vld       <= 1'b0;
      s4_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_vld       <= in_vld;
      s2_vld       <= s1_vld;
      s3_vld       <= s2_vld;
      s4_vld       <= s3_vld;
      result_valid <= s4_vld && s4_side.sample;
    end
  end

  assign red   = q_hit ? q[23:16] : 8'h00;
  assign green = q_hit ? q[15:8]  : 8'h00;
  assign blue  = q_hit ? q[7:0]   : 8'h00;

endmodule

[hdl/equirect_sky_texel_lookup.sv]
`timescale 1ns / 1ps
// channel  | handshake                       | payload
// ---------+---------------------------------+------------------------------------------
// request  | start, busy (accept: start&!busy)| req_type, dir_x/y/z, texel_index, texel_rgb
// result   | result_valid (one-cycle strobe) | red, green, blue, texel_x, texel_y
// config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata (64 bit, reg i at 8*i)
//
// one request transfer per cycle; busy is never raised
// a sample gives its result after the rotation, square root (one root bit per stage),
// latitude cordic (one iteration per stage) and texel lookup pipelines, in that order
// a texel write lands in the store at the same depth, so order with samples is kept
// rst is synchronous; it clears valid bits and config registers, not the texel store
// the receiver cannot stall: each result shows for exactly one cycle
module equirect_sky_texel_lookup import ests_pkg::*; #(
  parameter int MAX_TEXELS   = 262144,
  parameter int MAX_DIM      = 4096,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // request
  input  logic                    start,
  output logic                    busy,
  input  logic                    req_type,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  input  logic [IDX_W-1:0]        texel_index,
  input  logic [RGB_W-1:0]        texel_rgb,
  // result
  output logic                    result_valid,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic [11:0]             texel_x,
  output logic [11:0]             texel_y,
  // config
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [5:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);

  localparam int LAT_ROT   = 2;
  localparam int LAT_SQ    = ISQ_STEPS + 2;
  localparam int LAT_COR   = CORDIC_STEPS + 1;
  localparam int LAT_SIDE  = LAT_ROT + LAT_SQ + LAT_COR;
  localparam int LATENCY   = LAT_SIDE + 5;

  // config registers
  logic [ROW_W-1:0]  rot_row_x, rot_row_y, rot_row_z;
  logic [15:0]       u_shift, v_shift;
  logic [SIZE_W-1:0] image_width, image_height;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  // datapath
  logic                    accept;
  logic [LAT_SIDE-1:0]     vld_pipe;
  side_t                   side_in, side_out;
  logic signed [ROT_W-1:0] rx, ry, rz;
  logic [ROT_W-1:0]        ry_dly;
  logic [ROT_W-1:0]        radius;
  logic [ANG_W-1:0]        lon, lon_dly, lat;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row_x    <= 54'd65536;
      rot_row_y    <= 54'd65536 << 18;
      rot_row_z    <= 54'd65536 << 36;
      u_shift      <= '0;
      v_shift      <= '0;
      image_width  <= 13'd1;
      image_height <= 13'd1;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_ROT_X:    rot_row_x    <= pwdata[ROW_W-1:0];
        REG_ROT_Y:    rot_row_y    <= pwdata[ROW_W-1:0];
        REG_ROT_Z:    rot_row_z    <= pwdata[ROW_W-1:0];
        REG_SHIFT_U:  u_shift      <= pwdata[15:0];
        REG_SHIFT_V:  v_shift      <= pwdata[15:0];
        REG_WIDTH:    image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:   image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ROT_X:    prdata = 64'(rot_row_x);
      REG_ROT_Y:    prdata = 64'(rot_row_y);
      REG_ROT_Z:    prdata = 64'(rot_row_z);
      REG_SHIFT_U:  prdata = 64'(u_shift);
      REG_SHIFT_V:  prdata = 64'(v_shift);
      REG_WIDTH:    prdata = 64'(image_width);
      REG_HEIGHT:   prdata = 64'(image_height);
      default:      prdata = '0;
    endcase
  end

  // request transfer; write info and valid ride alongside the angle math
  assign accept          = start && !busy;
  assign side_in.sample  = req_type;
  assign side_in.idx     = texel_index;
  assign side_in.rgb     = texel_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[LAT_SIDE-2:0], accept};
    end
  end

  ests_delay #(.W($bits(side_t)), .DEPTH(LAT_SIDE)) u_side_dly (
    .clk (clk),
    .d   (side_in),
    .q   (side_out)
  );

  // rotate the direction by the matrix
  ests_rotate u_rotate (
    .clk   (clk),
    .dir_x (dir_x),
    .dir_y (dir_y),
    .dir_z (dir_z),
    .row_x (rot_row_x),
    .row_y (rot_row_y),
    .row_z (rot_row_z),
    .rx    (rx),
    .ry    (ry),
    .rz    (rz)
  );

  // longitude runs beside the square root, then waits for latitude
  ests_cordic #(.STEPS(CORDIC_STEPS)) u_lon (
    .clk  (clk),
    .x_in (CW'(rx)),
    .y_in (CW'(rz)),
    .ang  (lon)
  );

  ests_delay #(.W(ANG_W), .DEPTH(LAT_SQ)) u_lon_dly (
    .clk (clk),
    .d   (lon),
    .q   (lon_dly)
  );

  // horizontal radius sqrt(x*x + z*z)
  ests_isqrt u_isqrt (
    .clk  (clk),
    .rx   (rx),
    .rz   (rz),
    .root (radius)
  );

  ests_delay #(.W(ROT_W), .DEPTH(LAT_SQ)) u_ry_dly (
    .clk (clk),
    .d   (ry),
    .q   (ry_dly)
  );

  // latitude: radius is never negative
  ests_cordic #(.STEPS(CORDIC_STEPS)) u_lat (
    .clk  (clk),
    .x_in ($signed(CW'(radius))),
    .y_in (CW'($signed(ry_dly))),
    .ang  (lat)
  );

  // u/v, texel coordinates, store
  ests_texmap #(.MAX_TEXELS(MAX_TEXELS), .MAX_DIM(MAX_DIM)) u_texmap (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (vld_pipe[LAT_SIDE-1]),
    .side         (side_out),
    .lon          (lon_dly),
    .lat          (lat),
    .u_shift      (u_shift),
    .v_shift      (v_shift),
    .image_width  (image_width),
    .image_height (image_height),
    .result_valid (result_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .texel_x      (texel_x),
    .texel_y      (texel_y)
  );

endmodule

[hdl/ests_checker.sv]
`timescale 1ns / 1ps
module ests_checker #(
  parameter int LATENCY = 54
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic req_type,
  input logic result_valid
);

  // requests are never held off
  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result right after reset");

  // every result traces back to a sample transfer
  a_result_has_sample: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && req_type, LATENCY))
    else $error("result without a sample");

  // texel writes give no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !req_type) |-> ##LATENCY !result_valid)
    else $error("result from a texel write");

endmodule

bind equirect_sky_texel_lookup ests_checker #(.LATENCY(LATENCY)) u_ests_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .req_type     (req_type),
  .result_valid (result_valid)
);

[tb/sv/equirect_sky_texel_lookup_tb.sv]
`timescale 1ns / 1ps
module equirect_sky_texel_lookup_tb;
  import ests_pkg::*;

  localparam int STORE_DEPTH = 262144;
  localparam int PIPE_DEPTH  = 16 + 38;      // sample to result, writes land as deep
  localparam int CYCLE_LIMIT = 400000;       // far above the slowest correct run

  typedef struct {
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
    bit [11:0] col;
    bit [11:0] row;
  } texel_hit_t;

  // holds a mirror of the registers and the texel store, predicts each lookup
  class sky_lookup_scoreboard;
    bit [53:0]  row_x, row_y, row_z;
    bit [15:0]  off_u, off_v;
    bit [12:0]  width_reg, height_reg;
    bit [23:0]  texels [int];
    texel_hit_t expected_hits [$];
    int         errors;
    int         samples_seen;
    int         hits_checked;

    function new();
      row_x = 54'd65536;
      row_y = 54'd65536 << 18;
      row_z = 54'd65536 << 36;
      off_u = 0;
      off_v = 0;
      width_reg = 1;
      height_reg = 1;
    endfunction

    function void set_reg(cfg_reg_t which, bit [63:0] value);
      case (which)
        REG_ROT_X:    row_x = value[53:0];
        REG_ROT_Y:    row_y = value[53:0];
        REG_ROT_Z:    row_z = value[53:0];
        REG_SHIFT_U:  off_u = value[15:0];
        REG_SHIFT_V:  off_v = value[15:0];
        REG_WIDTH:    width_reg = value[12:0];
        REG_HEIGHT:   height_reg = value[12:0];
        default: ;
      endcase
    endfunction

    // one matrix row times the direction, Q.32 floored back to Q.16
    function longint rotate_row(bit [53:0] r, longint x, longint y, longint z);
      longint s;
      s = longint'($signed(r[17:0])) * x + longint'($signed(r[35:18])) * y
        + longint'($signed(r[53:36])) * z;
      return s >>> 16;
    endfunction

    function bit [31:0] binary_atan2(longint y, longint x);
      bit [31:0] ang;
      longint    sx, sy;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      // left half plane: turn by half a turn first
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
        sx = y >>> i;
        sy = x >>> i;
        if (y < 0) begin
          x -= sx;
          y += sy;
          ang -= ATAN_TAB[i];
        end else begin
          x += sx;
          y -= sy;
          ang += ATAN_TAB[i];
        end
      end
      return ang;
    endfunction

    function bit [63:0] floor_sqrt(bit [63:0] n);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint scale_to_texel(bit [31:0] frac, bit [12:0] size_reg);
      longint sz, p;
      sz = size_reg;
      if (sz > 4096) sz = 4096;
      if (sz == 0) return 0;
      p = ({32'd0, frac} * sz) >> 32;
      return (p > sz - 1) ? sz - 1 : p;
    endfunction

    // texel column, row and linear address that a direction lands on
    function void locate(longint x, longint y, longint z,
                         output longint col, output longint row, output longint addr);
      longint    rx, ry, rz, w;
      bit [31:0] lon, lat, u, v;
      bit [63:0] rad;
      rx = rotate_row(row_x, x, y, z);
      ry = rotate_row(row_y, x, y, z);
      rz = rotate_row(row_z, x, y, z);
      lon = binary_atan2(rz, rx);
      rad = floor_sqrt(64'(rx * rx) + 64'(rz * rz));
      lat = binary_atan2(ry, longint'(rad));
      u = 32'h80000000 - lon + {off_u, 16'd0};
      v = 32'h80000000 - (lat << 1) + {off_v, 16'd0};
      col = scale_to_texel(u, width_reg);
      row = scale_to_texel(v, height_reg);
      w = (width_reg > 4096) ? 4096 : width_reg;
      addr = row * w + col;
    endfunction

    function bit needs_fill(longint addr);
      return addr < STORE_DEPTH && !texels.exists(int'(addr));
    endfunction

    // an accepted request transfer
    function void note_request(bit is_sample, longint x, longint y, longint z,
                               bit [17:0] idx, bit [23:0] rgb);
      longint     col, row, addr;
      texel_hit_t hit;
      bit [23:0]  c;
      if (!is_sample) begin
        texels[int'(idx)] = rgb;
        return;
      end
      locate(x, y, z, col, row, addr);
      c = (addr < STORE_DEPTH) ? texels[int'(addr)] : 24'd0;
      hit.red = c[23:16];
      hit.green = c[15:8];
      hit.blue = c[7:0];
      hit.col = col[11:0];
      hit.row = row[11:0];
      expected_hits.push_back(hit);
      samples_seen++;
    endfunction

    function void check_hit(texel_hit_t got);
      texel_hit_t want;
      if (expected_hits.size() == 0) begin
        $error("result with no sample outstanding");
        errors++;
        return;
      end
      want = expected_hits.pop_front();
      hits_checked++;
      if (got.red != want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.green != want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.blue != want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
      if (got.col != want.col) begin
        $error("texel_x: expected %0d, got %0d", want.col, got.col);
        errors++;
      end
      if (got.row != want.row) begin
        $error("texel_y: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    req_type;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
  logic [IDX_W-1:0]        texel_index;
  logic [RGB_W-1:0]        texel_rgb;
  logic                    result_valid;
  logic [7:0]              red, green, blue;
  logic [11:0]             texel_x, texel_y;
  logic                    psel, penable, pwrite;
  logic [5:0]              paddr;
  logic [63:0]             pwdata;
  logic [63:0]             prdata;
  logic                    pready;

  sky_lookup_scoreboard sb;
  int  idle_pct;          // chance in percent of a sender gap before each transfer
  int  cycle_count;
  int  reg_writes;

  equirect_sky_texel_lookup dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .req_type(req_type),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .texel_index(texel_index), .texel_rgb(texel_rgb),
    .result_valid(result_valid), .red(red), .green(green), .blue(blue),
    .texel_x(texel_x), .texel_y(texel_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[equirect_sky_texel_lookup] ERROR");
      $finish;
    end
  end

  // result side: every strobe is one transfer, nothing can hold it off
  always @(posedge clk) begin
    texel_hit_t got;
    if (!rst && result_valid) begin
      got.red = red;
      got.green = green;
      got.blue = blue;
      got.col = texel_x;
      got.row = texel_y;
      sb.check_hit(got);
    end
  end

  // one request transfer, with an optional random gap in front
  task automatic push_request(bit is_sample, longint x, longint y, longint z,
                              bit [17:0] idx, bit [23:0] rgb);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= is_sample;
    dir_x <= x[23:0];
    dir_y <= y[23:0];
    dir_z <= z[23:0];
    texel_index <= idx;
    texel_rgb <= rgb;
    do @(posedge clk); while (busy);
    sb.note_request(is_sample, x, y, z, idx, rgb);
  endtask

  task automatic texel_write(bit [17:0] idx, bit [23:0] rgb);
    push_request(1'b0, longint'($urandom), longint'($urandom), longint'($urandom), idx, rgb);
  endtask

  // a sample whose texel was never loaded gets a write to that texel first
  task automatic texel_sample(longint x, longint y, longint z);
    longint col, row, addr;
    sb.locate(x, y, z, col, row, addr);
    if (sb.needs_fill(addr)) texel_write(addr[17:0], 24'($urandom));
    push_request(1'b1, x, y, z, 18'($urandom), 24'($urandom));
  endtask

  // wait until every sample has come back and the pipeline has emptied
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_hits.size() != 0);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic reg_write(cfg_reg_t which, bit [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(which) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(which, value);
    reg_writes++;
  endtask

  function automatic bit [63:0] random_row();
    return {$urandom, $urandom} & 64'h003F_FFFF_FFFF_FFFF;
  endfunction

  function automatic longint signed_field(bit [23:0] raw);
    return longint'($signed(raw));
  endfunction

  task automatic random_sample();
    longint x, y, z;
    case ($urandom_range(4))
      0, 1: begin
        x = signed_field(24'($urandom));
        y = signed_field(24'($urandom));
        z = signed_field(24'($urandom));
      end
      2: begin
        x = longint'($urandom_range(600)) - 300;
        y = longint'($urandom_range(600)) - 300;
        z = longint'($urandom_range(600)) - 300;
      end
      3: begin
        // some components zero, including the all-zero direction
        x = $urandom_range(1) ? signed_field(24'($urandom)) : 0;
        y = $urandom_range(1) ? signed_field(24'($urandom)) : 0;
        z = $urandom_range(1) ? signed_field(24'($urandom)) : 0;
      end
      default: begin
        // unit-ish directions along an axis, either sign
        x = 0;
        y = 0;
        z = 0;
        case ($urandom_range(2))
          0: x = $urandom_range(1) ? 65536 : -65536;
          1: y = $urandom_range(1) ? 65536 : -65536;
          default: z = $urandom_range(1) ? 65536 : -65536;
        endcase
      end
    endcase
    texel_sample(x, y, z);
  endtask

  initial begin
    bit [12:0] widths [5];
    bit [12:0] heights [5];
    int        idle_by_phase [5];

    sb = new();
    cycle_count = 0;
    reg_writes = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    req_type = 1'b0;
    dir_x = '0;
    dir_y = '0;
    dir_z = '0;
    texel_index = '0;
    texel_rgb = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config is a 1x1 image, so every sample hits texel 0
    texel_write(18'd0, 24'hFFFFFF);
    texel_write(18'h3FFFF, 24'h000000);
    texel_write(18'd1, 24'h5AA5C3);
    texel_sample(0, 0, 0);                       // zero direction
    texel_sample(65536, 0, 0);
    texel_sample(-65536, 0, 0);                  // negative x takes the half-turn path
    texel_sample(-65536, 0, -1);
    texel_sample(0, 65536, 0);
    texel_sample(0, -65536, 0);
    texel_sample(0, 0, 65536);
    texel_sample(0, 0, -65536);
    texel_sample(8388607, 8388607, 8388607);
    texel_sample(-8388608, -8388608, -8388608);
    texel_sample(-8388608, 8388607, 0);
    texel_write(18'd0, 24'h123456);
    texel_sample(-1, 0, 0);
    drain();

    // bigger image: now the angles matter
    reg_write(REG_WIDTH, 64'd64);
    reg_write(REG_HEIGHT, 64'd32);
    reg_write(REG_SHIFT_U, 64'd0);
    reg_write(REG_SHIFT_V, 64'hFFFF);
    texel_sample(0, 0, 0);
    texel_sample(-65536, 0, 0);
    texel_sample(-65536, 0, 65536);
    texel_sample(-65536, 0, -65536);
    texel_sample(0, 8388607, 0);
    texel_sample(0, -8388608, 0);
    texel_sample(8388607, -8388608, 8388607);
    drain();

    // per phase: image size extremes, sender idling
    widths  = '{13'd64, 13'd4096, 13'd8191, 13'd0, 13'($urandom_range(600, 1))};
    heights = '{13'd32, 13'd4096, 13'd0, 13'd8191, 13'($urandom_range(400, 1))};
    idle_by_phase = '{0, 65, 22, 65, 0};

    for (int ph = 0; ph < 5; ph++) begin
      // matrix: extremes and identity in the first phases, random later
      case (ph)
        0: begin
          reg_write(REG_ROT_X, 64'h003F_FFFF_FFFF_FFFF);
          reg_write(REG_ROT_Y, 64'd0);
          reg_write(REG_ROT_Z, 64'h0020_0008_0002_0000);  // most negative coefficients
        end
        1: begin
          reg_write(REG_ROT_X, 64'd65536);
          reg_write(REG_ROT_Y, 64'd65536 << 18);
          reg_write(REG_ROT_Z, 64'd65536 << 36);
        end
        2: begin
          reg_write(REG_ROT_X, 64'h001F_FFF7_FFFD_FFFF);  // most positive coefficients
          reg_write(REG_ROT_Y, random_row());
          reg_write(REG_ROT_Z, random_row());
        end
        default: begin
          reg_write(REG_ROT_X, random_row());
          reg_write(REG_ROT_Y, random_row());
          reg_write(REG_ROT_Z, random_row());
        end
      endcase
      reg_write(REG_SHIFT_U, (ph == 1) ? 64'hFFFF : 64'($urandom_range(65535)));
      reg_write(REG_SHIFT_V, (ph == 1) ? 64'h0 : 64'($urandom_range(65535)));
      reg_write(REG_WIDTH, 64'(widths[ph]));
      reg_write(REG_HEIGHT, 64'(heights[ph]));
      idle_pct = idle_by_phase[ph];

      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(3) == 0) texel_write(18'($urandom), 24'($urandom));
        else random_sample();
        // sender holds off until everything outstanding is back
        if (n == 50) drain();
      end
      drain();
    end

    $display("covered %0d samples checked against %0d results, %0d register writes,",
             sb.samples_seen, sb.hits_checked, reg_writes);
    $display("5 random phases over image sizes 0 to 8191 and extreme rotation matrices");
    if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
      $display("[equirect_sky_texel_lookup] OK");
    end else begin
      $display("[equirect_sky_texel_lookup] ERROR");
    end
    $finish;
  end

endmodule
